/* rtl/core/crst_pkg.sv */
// crst_pkg: shared constants and types for the catmull-rom segment tessellator
// no dependencies
package crst_pkg;

    localparam int T_FRAC      = 16;   // t is q1.16
    localparam int T_BITS      = 17;   // holds 0 .. 65536
    localparam int STEP_BITS   = 6;
    localparam int DIV_BITS    = 18;   // dividend 2^17
    localparam int COEF_EXTRA  = 4;    // hermite coefficient growth over a coordinate
    localparam int ACC_EXTRA   = 6;    // horner accumulator growth
    localparam int NUM_AXES    = 3;
    localparam int NUM_COEFS   = 4;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* rtl/core/crst_queue.sv */
// crst_queue: short segment job queue between front and back
// depends on crst_pkg
module crst_queue #(
    parameter int WIDTH = 336
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [WIDTH-1:0]    i_data,
    input  logic                i_pop,
    output logic [WIDTH-1:0]    o_data,
    output crst_pkg::t_q_status o_status
);
    import crst_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [PW:0]      r_cnt;
    logic             do_push, do_pop;

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_status.full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_data = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* rtl/core/crst_front.sv */
// crst_front: point window, curve start handling and hermite coefficients per segment
// depends on crst_pkg
module crst_front #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [3*COORD_WIDTH-1:0]      i_point,
    input  logic                          i_start,
    input  crst_pkg::t_q_status           i_q_status,
    output logic                          o_push,
    output logic [12*(COORD_WIDTH+4)-1:0] o_job
);
    import crst_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int KW = CW + COEF_EXTRA;

    logic signed [CW-1:0] r_win [3][NUM_AXES];   // three earlier points, oldest first
    logic [1:0]           r_held;
    logic                 acc_beat, full;
    logic signed [KW-1:0] p0, p1, p2, p3;
    logic signed [KW-1:0] a2 [NUM_AXES];
    logic signed [KW-1:0] b2 [NUM_AXES];
    logic signed [KW-1:0] c2 [NUM_AXES];
    logic signed [KW-1:0] d2 [NUM_AXES];

    assign o_ready  = !i_q_status.full;
    assign acc_beat = i_valid && o_ready;
    assign full     = !i_start && (r_held == 2'd3);
    assign o_push   = acc_beat && full;

    always_comb begin
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            p0 = KW'(r_win[0][ax]);
            p1 = KW'(r_win[1][ax]);
            p2 = KW'(r_win[2][ax]);
            p3 = KW'($signed(i_point[ax*CW +: CW]));
            a2[ax] = KW'(-p0 + 3 * p1 - 3 * p2 + p3);
            b2[ax] = KW'(2 * p0 - 5 * p1 + 4 * p2 - p3);
            c2[ax] = p2 - p0;
            d2[ax] = KW'(2 * p1);
            o_job[(ax*NUM_COEFS+0)*KW +: KW] = a2[ax];
            o_job[(ax*NUM_COEFS+1)*KW +: KW] = b2[ax];
            o_job[(ax*NUM_COEFS+2)*KW +: KW] = c2[ax];
            o_job[(ax*NUM_COEFS+3)*KW +: KW] = d2[ax];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_beat) begin
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                r_win[0][ax] <= r_win[1][ax];
                r_win[1][ax] <= r_win[2][ax];
                r_win[2][ax] <= $signed(i_point[ax*CW +: CW]);
            end
        end
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (acc_beat) begin
            if (i_start) begin
                r_held <= 2'd1;
            end else if (r_held != 2'd3) begin
                r_held <= r_held + 2'd1;
            end
        end
    end

endmodule

/* rtl/core/crst_back.sv */
// crst_back: per-segment sample sequencer, t stepping and horner evaluation
// depends on crst_pkg
module crst_back #(
    parameter int COORD_WIDTH = 24,
    parameter int MAX_STEPS   = 63
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [crst_pkg::STEP_BITS-1:0] i_steps,
    input  crst_pkg::t_q_status           i_q_status,
    input  logic [12*(COORD_WIDTH+4)-1:0] i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [3*COORD_WIDTH-1:0]      o_sample,
    output logic                          o_last
);
    import crst_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int KW = CW + COEF_EXTRA;
    localparam int AW = CW + ACC_EXTRA;
    localparam int PW = AW + T_BITS + 1;
    localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (CW-1)) - 1);
    localparam logic signed [AW-1:0] SAT_LO = AW'(-(64'sd1 <<< (CW-1)));

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_LOAD, S_MUL, S_ADD, S_SAMP, S_EMIT} t_state;

    t_state                r_state;
    logic [STEP_BITS-1:0]  r_steps, r_k, eff_steps;
    logic [4:0]            r_div_cnt;
    logic [7:0]            r_rem;
    logic [T_BITS-1:0]     r_q;       // 2^17 / (2*steps)
    logic [6:0]            r_r0;      // its remainder
    logic [T_BITS-1:0]     r_t;
    logic [7:0]            r_tr;
    logic [1:0]            r_ax, r_h;
    logic signed [AW-1:0]  r_acc;
    logic signed [PW-1:0]  r_prod;
    logic signed [CW-1:0]  r_res [NUM_AXES];
    logic [7:0]            div_d, div_rem, t_sum;
    logic                  div_bit;
    logic                  emit;
    logic signed [KW-1:0]  coef_a, coef_next;
    logic signed [AW-1:0]  rounded, half;

    always_comb begin
        if (i_steps == '0) begin
            eff_steps = STEP_BITS'(1);
        end else if (i_steps > STEP_BITS'(MAX_STEPS)) begin
            eff_steps = STEP_BITS'(MAX_STEPS);
        end else begin
            eff_steps = i_steps;
        end
        div_d   = {1'b0, r_steps, 1'b0};
        div_bit = (r_div_cnt == 5'(DIV_BITS-1));
        div_rem = {r_rem[6:0], div_bit};
        t_sum   = r_tr + {1'b0, r_r0};
        coef_a  = $signed(i_job[(r_ax*NUM_COEFS)*KW +: KW]);
        coef_next = $signed(i_job[(r_ax*NUM_COEFS + r_h + 2'd1)*KW +: KW]);
        rounded = AW'((r_prod + (PW'(1) <<< (T_FRAC-1))) >>> T_FRAC);
        half    = (r_acc + AW'(1)) >>> 1;
    end

    // a sample leaves when the output register is free or being drained
    assign emit  = (r_state == S_EMIT) && (!o_valid || i_ready);
    assign o_pop = emit && (r_k == r_steps);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (emit) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_status.empty) begin
                        r_steps   <= eff_steps;
                        r_div_cnt <= 5'(DIV_BITS-1);
                        r_rem     <= '0;
                        r_q       <= '0;
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    // restoring divide, one quotient bit a cycle
                    if (div_rem >= div_d) begin
                        r_rem <= div_rem - div_d;
                        r_q   <= {r_q[T_BITS-2:0], 1'b1};
                    end else begin
                        r_rem <= div_rem;
                        r_q   <= {r_q[T_BITS-2:0], 1'b0};
                    end
                    if (r_div_cnt == '0) begin
                        r_k     <= '0;
                        r_t     <= '0;
                        r_tr    <= {2'b00, r_steps};
                        r_ax    <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_div_cnt <= r_div_cnt - 1'b1;
                    end
                end
                S_LOAD: begin
                    if (r_div_cnt == '0 && r_k == '0 && r_ax == '0) begin
                        r_r0 <= r_rem[6:0];
                    end
                    r_acc   <= AW'(coef_a);
                    r_h     <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= PW'(r_acc * $signed({1'b0, r_t}));
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_acc <= rounded + AW'(coef_next);
                    if (r_h == 2'd2) begin
                        r_state <= S_SAMP;
                    end else begin
                        r_h     <= r_h + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_SAMP: begin
                    if (half > SAT_HI) begin
                        r_res[r_ax] <= CW'(SAT_HI);
                    end else if (half < SAT_LO) begin
                        r_res[r_ax] <= CW'(SAT_LO);
                    end else begin
                        r_res[r_ax] <= CW'(half);
                    end
                    if (r_ax == 2'd2) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_LOAD;
                    end
                end
                S_EMIT: begin
                    if (emit) begin
                        for (int ax = 0; ax < NUM_AXES; ax++) begin
                            o_sample[ax*CW +: CW] <= r_res[ax];
                        end
                        o_last <= (r_k == r_steps);
                        if (r_k == r_steps) begin
                            r_state <= S_IDLE;
                        end else begin
                            // t advances by q with carry from the running remainder
                            if (t_sum >= div_d) begin
                                r_t  <= r_t + r_q + T_BITS'(1);
                                r_tr <= t_sum - div_d;
                            end else begin
                                r_t  <= r_t + r_q;
                                r_tr <= t_sum;
                            end
                            r_k     <= r_k + 1'b1;
                            r_ax    <= '0;
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/core/catmull_rom_segment_tessellator_unit.sv */
// catmull_rom_segment_tessellator_unit: top level of the uniform catmull-rom tessellator
// depends on crst_pkg, crst_front, crst_queue, crst_back
//
// usage
//   slave stream takes one control point a beat; tdata = x, y, z (signed q16.8 at
//   COORD_WIDTH), tuser = start of a new curve. from the fourth point of a curve on,
//   every point closes a segment from the second-oldest to the second-newest point.
//   master stream gives steps+1 samples per segment, tdata = x, y, z saturated,
//   tlast on the sample at t = 1.
//   the cfg channel writes steps_per_segment (0 acts as 1, above MAX_STEPS as MAX_STEPS);
//   write it only while idle.
//   each segment starts with picking up the job and a restoring divide for the t step;
//   then each sample runs, per axis, a load, three multiply/add horner steps through
//   one multiplier and a saturate, and ends with one emit. the sampler takes no new
//   job until the last sample of its segment has left.
//   a two-entry segment queue lets points be taken while earlier segments are
//   still being sampled; tready falls when it is full.
//   reset (synchronous, active low) empties the window, the queue and the output;
//   steps returns to 16. a stalled receiver holds the sample in the output
//   register and the sampler waits on it.
module catmull_rom_segment_tessellator_unit #(
    parameter int COORD_WIDTH = 24,
    parameter int MAX_STEPS   = 63
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     i_s_tdata,  // point_x, point_y, point_z
    input  logic                                   i_s_tuser,  // start_curve
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]     o_m_tdata,  // sample_x, sample_y, sample_z
    output logic                                   o_m_tlast,  // segment_end
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [crst_pkg::STEP_BITS-1:0]         i_cfg_data
);
    import crst_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int DW = ((3*CW+7)/8)*8;
    localparam int JW = 12*(CW+4);

    logic [STEP_BITS-1:0] r_steps;
    t_q_status            q_status;
    logic                 push, pop;
    logic [JW-1:0]        job_in, job_out;
    logic [3*CW-1:0]      sample;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= STEP_BITS'(16);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_steps <= i_cfg_data;
        end
    end

    crst_front #(.COORD_WIDTH(CW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_point    (i_s_tdata[3*CW-1:0]),
        .i_start    (i_s_tuser),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (job_in)
    );

    crst_queue #(.WIDTH(JW)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (job_in),
        .i_pop    (pop),
        .o_data   (job_out),
        .o_status (q_status)
    );

    crst_back #(.COORD_WIDTH(CW), .MAX_STEPS(MAX_STEPS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_steps    (r_steps),
        .i_q_status (q_status),
        .i_job      (job_out),
        .o_pop      (pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_sample   (sample),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = DW'(sample);

endmodule

/* rtl/core/crst_checker.sv */
// crst_checker: port-level checks for the tessellator, bound to the top level
// depends on crst_pkg and catmull_rom_segment_tessellator_unit
module crst_checker #(
    parameter int COORD_WIDTH = 24
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_s_tready,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [((3*COORD_WIDTH+7)/8)*8-1:0]  o_m_tdata,
    input logic                                o_m_tlast,
    input logic                                o_cfg_ready
);
    import crst_pkg::*;

    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_reset_in: assert property (@(posedge i_clk) !i_rst_n |=> o_s_tready)
        else $error("input not ready after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled output beat changed");

    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_cfg_ready)
        else $error("cfg channel not ready");

endmodule

bind catmull_rom_segment_tessellator_unit crst_checker #(.COORD_WIDTH(COORD_WIDTH)) u_crst_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tlast   (o_m_tlast),
    .o_cfg_ready (o_cfg_ready)
);
